FILE: hw/rtl/adc_ma_pkg.sv
// Shared constants and types for the ADC moving average block.
package adc_ma_pkg;

   localparam int DEPTH       = 100;
   localparam int SAMPLE_BITS = 12;

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   // Widths of the result fields as seen on the port.
   localparam int AVG_W     = 12;
   localparam int CNT_OUT_W = 7;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

endpackage

FILE: hw/rtl/adc_ma_if.sv
// Handshake interfaces for the sample and result channels.
interface adc_ma_req_if;
   import adc_ma_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface adc_ma_rsp_if;
   import adc_ma_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [AVG_W-1:0]     average;
   logic [CNT_OUT_W-1:0] valid_count;
   modport source (output valid, output average, output valid_count, input ready);
   modport sink (input valid, input average, input valid_count, output ready);
endinterface

FILE: hw/rtl/adc_moving_average.sv
// Boxcar moving average with warm-up over a ring of recent ADC samples.
//
//   channel | direction | words carried
//   --------+-----------+-----------------------------------------
//   req     | in        | sample
//   rsp     | out       | average, valid_count
//
// A word passes from acceptance to the load of its result through the update
// step, SUM_W (19) divider steps, a step to see the divider finish and the load
// itself; a new word is accepted only after the last one's result is loaded.
// Reset empties the window at once; the ring itself needs no clearing.
// A stalled result holds in the output register while the next word is worked
// on; that word waits in its final state until the register is free.
module adc_moving_average (
   input logic           clock,
   input logic           reset,
   adc_ma_req_if.sink    req_chan,
   adc_ma_rsp_if.source  rsp_chan
);
   import adc_ma_pkg::*;

   logic [SAMPLE_BITS-1:0] ring [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       widx_ff, widx_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] sample_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [AVG_W-1:0]       out_avg_ff;
   logic [CNT_OUT_W-1:0]   out_cnt_ff;

   logic                   accept;
   logic                   full;
   logic                   upd;
   logic                   load;
   logic                   div_done;
   logic [SUM_W-1:0]       quotient;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (fill_ff == CNT_W'(DEPTH));
   assign upd            = (state_ff == ST_UPDATE);
   assign load           = (state_ff == ST_DONE) && (!out_valid_ff || rsp_chan.ready);

   // The oldest sample leaves the sum only once the window is full.
   always_comb begin
      widx_in = widx_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (upd) begin
         sum_in  = sum_ff - (full ? SUM_W'(rd_data_ff) : '0) + SUM_W'(sample_ff);
         fill_in = full ? fill_ff : fill_ff + 1'b1;
         widx_in = (widx_ff == IDX_W'(DEPTH - 1)) ? '0 : widx_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_done) state_in = ST_DONE;
         ST_DONE:   if (load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         widx_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Sample ring: read on acceptance, written back in the update cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= ring[widx_ff];
         sample_ff  <= req_chan.sample;
      end
      if (upd) begin
         ring[widx_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_avg_ff <= quotient[AVG_W-1:0];
         out_cnt_ff <= CNT_OUT_W'(fill_ff);
      end
   end

   adc_ma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (upd),
      .dividend (sum_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.average     = out_avg_ff;
   assign rsp_chan.valid_count = out_cnt_ff;

endmodule

FILE: hw/rtl/adc_ma_div.sv
// Restoring divider that produces one quotient bit per cycle.
module adc_ma_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [adc_ma_pkg::SUM_W-1:0] dividend,
   input  logic [adc_ma_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [adc_ma_pkg::SUM_W-1:0] quotient
);
   import adc_ma_pkg::*;

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   // The partial remainder stays below the divisor, so one extra bit holds the trial.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/adc_ma_checker.sv
// Port-level checks for the ADC moving average, bound to the top level.
module adc_ma_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [adc_ma_pkg::AVG_W-1:0]     rsp_average,
   input logic [adc_ma_pkg::CNT_OUT_W-1:0] rsp_valid_count
);
   import adc_ma_pkg::*;

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_average) && $stable(rsp_valid_count)))
      else $error("result word changed while stalled");

   // The count reported always lies between one and the window depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_valid_count >= CNT_OUT_W'(1) &&
                     rsp_valid_count <= CNT_OUT_W'(DEPTH)))
      else $error("valid_count outside the window range");

   // Only one word is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("sample accepted while another is in progress");

endmodule

bind adc_moving_average adc_ma_checker u_adc_ma_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_average     (rsp_chan.average),
   .rsp_valid_count (rsp_chan.valid_count)
);
